FILE: src/arw_pkg.sv
package arw_pkg;

  // window length in packet numbers, newest bit is WinSize-1
  localparam int WinSize = 64;
  localparam int IdxW    = $clog2(WinSize);

  localparam int OpW      = 2;
  localparam int PnW      = 64;
  localparam int SeqW     = 32;
  localparam int VerdictW = 3;

  typedef logic [WinSize-1:0] map_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [PnW-1:0]     pn_t;
  typedef logic [SeqW-1:0]    seq_t;

  // request operations
  typedef enum logic [OpW-1:0] {
    OpCheck  = 2'd0,
    OpCommit = 2'd1,
    OpClear  = 2'd2
  } op_t;

  // result verdicts
  typedef enum logic [VerdictW-1:0] {
    VNew      = 3'd0,
    VInside   = 3'd1,
    VMismatch = 3'd2,
    VSeen     = 3'd3,
    VOld      = 3'd4
  } verdict_t;

  // request held in the input register
  typedef struct packed {
    logic [OpW-1:0] op;
    pn_t            packet_number;
    seq_t           wire_seq;
  } req_t;

  // result held in the output register
  typedef struct packed {
    logic [VerdictW-1:0] verdict;
    pn_t                 highest_seen;
  } res_t;

endpackage

FILE: src/arw_if.sv
interface arw_in_if;
  logic                          valid;
  logic                          ready;
  logic [arw_pkg::OpW-1:0]       op;
  logic [arw_pkg::PnW-1:0]       packet_number;
  logic [arw_pkg::SeqW-1:0]      wire_seq;

  modport source (output valid, output op, output packet_number, output wire_seq,
                  input ready);
  modport sink   (input valid, input op, input packet_number, input wire_seq,
                  output ready);
endinterface

interface arw_out_if;
  logic                          valid;
  logic                          ready;
  logic [arw_pkg::VerdictW-1:0]  verdict;
  logic [arw_pkg::PnW-1:0]       highest_seen;

  modport source (output valid, output verdict, output highest_seen, input ready);
  modport sink   (input valid, input verdict, input highest_seen, output ready);
endinterface

FILE: src/arw_core.sv
module arw_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  arw_pkg::req_t     req,
  output arw_pkg::res_t     res
);

  localparam arw_pkg::map_t NewestBit = {1'b1, {(arw_pkg::WinSize-1){1'b0}}};

  arw_pkg::pn_t  hp_r, hp_nxt;
  arw_pkg::map_t map_r, map_nxt;

  arw_pkg::pn_t  lag;
  arw_pkg::pn_t  jump;
  logic          above;
  logic          in_win;
  arw_pkg::idx_t pos;
  logic          marked;
  logic [arw_pkg::VerdictW-1:0] win_verdict;
  logic [arw_pkg::VerdictW-1:0] verdict;
  arw_pkg::map_t map_set;

  // distance of the packet number from the window head
  assign above  = req.packet_number > hp_r;
  assign lag    = hp_r - req.packet_number;
  assign jump   = req.packet_number - hp_r;
  assign in_win = (req.packet_number != '0) && !above &&
                  (lag < arw_pkg::PnW'(arw_pkg::WinSize));
  assign pos    = arw_pkg::IdxW'(arw_pkg::WinSize - 1) - lag[arw_pkg::IdxW-1:0];
  assign marked = in_win && map_r[pos];

  // verdict against the window, sequence match assumed
  always_comb begin
    if (above) begin
      win_verdict = arw_pkg::VNew;
    end else if (in_win) begin
      win_verdict = marked ? arw_pkg::VSeen : arw_pkg::VInside;
    end else begin
      win_verdict = arw_pkg::VOld;
    end
  end

  // bitmap with the in-window bit marked
  always_comb begin
    map_set = map_r;
    if (in_win) begin
      map_set[pos] = 1'b1;
    end
  end

  // decision and next window state
  always_comb begin
    verdict = arw_pkg::VNew;
    hp_nxt  = hp_r;
    map_nxt = map_r;
    case (req.op)
      arw_pkg::OpCheck: begin
        if (req.packet_number[arw_pkg::SeqW-1:0] != req.wire_seq) begin
          verdict = arw_pkg::VMismatch;
        end else begin
          verdict = win_verdict;
        end
      end
      arw_pkg::OpCommit: begin
        verdict = win_verdict;
        if (win_verdict == arw_pkg::VNew) begin
          hp_nxt = req.packet_number;
          if (jump >= arw_pkg::PnW'(arw_pkg::WinSize)) begin
            map_nxt = NewestBit;
          end else begin
            map_nxt = (map_r >> jump[arw_pkg::IdxW-1:0]) | NewestBit;
          end
        end else if (win_verdict == arw_pkg::VInside) begin
          map_nxt = map_set;
        end
      end
      arw_pkg::OpClear: begin
        hp_nxt  = '0;
        map_nxt = '0;
      end
      default: begin
        verdict = arw_pkg::VNew;
      end
    endcase
  end

  assign res.verdict      = verdict;
  assign res.highest_seen = hp_nxt;

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r  <= '0;
      map_r <= '0;
    end else if (step) begin
      hp_r  <= hp_nxt;
      map_r <= map_nxt;
    end
  end

  // a clear empties the window
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && (req.op == arw_pkg::OpClear) |=> (hp_r == '0) && (map_r == '0))
    else $error("window not empty after clear");

  // state only moves on a request
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(hp_r) && $stable(map_r))
    else $error("window state moved without a request");

  // a nonzero head always has its own bit marked
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    (hp_r != '0) |-> map_r[arw_pkg::WinSize-1])
    else $error("newest bit missing for committed head");

  // a commit never reports a sequence mismatch
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    step && (req.op == arw_pkg::OpCommit) |-> (verdict != arw_pkg::VMismatch))
    else $error("commit reported sequence mismatch");

endmodule

FILE: src/anti_replay_window.sv
// Anti-replay window for one security association. Each request (check, commit
// or clear) gives exactly one result, in order. One request is taken every
// cycle while the output is not stalled; a request passes from the input
// register, where the decision logic compares the packet number with the
// window head, looks up or shifts the bitmap and updates the state, to the
// output register, where its result is presented until it is taken.
// A stalled result holds its request and every later one until it is taken.
// The output register lets a new request in while a result waits to be taken.
// Send a commit only after the packet has passed authentication.
module anti_replay_window (
  input  logic           clk,
  input  logic           rst_n,
  arw_in_if.sink         in_ch,
  arw_out_if.source      out_ch
);

  logic          s1_valid_r;
  arw_pkg::req_t s1_req_r;
  logic          out_valid_r;
  arw_pkg::res_t out_res_r;

  logic          out_free;
  logic          s1_go;
  logic          in_fire;
  arw_pkg::res_t res;

  // handshake control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // window decision and state
  arw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .req   (s1_req_r),
    .res   (res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // input and output payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.op            <= in_ch.op;
      s1_req_r.packet_number <= in_ch.packet_number;
      s1_req_r.wire_seq      <= in_ch.wire_seq;
    end
    if (s1_go) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = out_res_r.verdict;
  assign out_ch.highest_seen = out_res_r.highest_seen;

endmodule
